// ----- rtl/core/zawo_pkg.sv -----
`default_nettype none

package zawo_pkg;

  localparam int unsigned PidW   = 16;
  localparam int unsigned DriveW = 17;
  localparam int unsigned DutyW  = 16;
  localparam int unsigned ZoneW  = 2;
  localparam int unsigned OwnW   = 2;

  // floor(a * 32 / 25) == (a * RECIP_MULT) >> RECIP_SHIFT for a <= 32768
  localparam int unsigned RecipW = 22;
  localparam int unsigned ProdW  = PidW + RecipW;
  localparam logic [RecipW-1:0] RECIP_MULT = 22'd2684355;
  localparam int unsigned RECIP_SHIFT = 21;

  localparam logic [DutyW-1:0] VENT_THRESHOLD_RESET = 16'd2560;

  localparam logic [ZoneW-1:0] ZONE_LEFT  = 2'd0;
  localparam logic [ZoneW-1:0] ZONE_MID   = 2'd1;
  localparam logic [ZoneW-1:0] ZONE_RIGHT = 2'd2;

  localparam logic [OwnW-1:0] OWN_FREE        = 2'd0;
  localparam logic [OwnW-1:0] LEFT_WIN_LEFT   = 2'd1;
  localparam logic [OwnW-1:0] LEFT_WIN_MID    = 2'd2;
  localparam logic [OwnW-1:0] RIGHT_WIN_MID   = 2'd1;
  localparam logic [OwnW-1:0] RIGHT_WIN_RIGHT = 2'd2;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2
  } win_cmd_t;

  typedef struct packed {
    win_cmd_t        cmd;
    logic [OwnW-1:0] owner;
  } win_upd_t;

  // fields from high bit down, so zone_echo lands in the low bits of tdata
  typedef struct packed {
    logic [OwnW-1:0]   right_window_owner;
    logic [OwnW-1:0]   left_window_owner;
    win_cmd_t          right_window_cmd;
    win_cmd_t          left_window_cmd;
    logic              exhaust_side;
    logic [DutyW-1:0]  exhaust_duty;
    logic [DutyW-1:0]  heater_duty;
    logic [DutyW-1:0]  fan_duty;
    logic [DriveW-1:0] drive;
    logic [ZoneW-1:0]  zone_echo;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned OutW    = 80;
  localparam int unsigned InW     = 24;

  function automatic win_upd_t window_update(input logic [OwnW-1:0] owner,
                                             input logic [OwnW-1:0] me,
                                             input logic vent);
    win_upd_t r;
    r.cmd   = CMD_NONE;
    r.owner = owner;
    if (vent) begin
      if (owner == OWN_FREE) begin
        r.cmd   = CMD_OPEN;
        r.owner = me;
      end
    end else if (owner == me) begin
      r.cmd   = CMD_CLOSE;
      r.owner = OWN_FREE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/zone_actuator_window_ownership.sv -----
// Pipeline: input register (s1), then result register (res); the result register loads
//   while the output is empty or its result is being accepted.
// Throughput: one item per cycle unless m_axis_tready stalls the output; the path is one
//   16x22 reciprocal multiply for the scale by 32/25, then the vent compare and the window owner update.
// Reset (rst, synchronous): both windows free, vent_threshold = 2560, pipeline empty.
`default_nettype none

module zone_actuator_window_ownership
  import zawo_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [InW-1:0]    s_axis_tdata,   // zone[1:0], pid_out[17:2], zero pad
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [OutW-1:0]        m_axis_tdata,   // zone_echo[1:0], drive[18:2],
                                                 // fan_duty[34:19], heater_duty[50:35],
                                                 // exhaust_duty[66:51], exhaust_side[67],
                                                 // left_window_cmd[69:68],
                                                 // right_window_cmd[71:70],
                                                 // left_window_owner[73:72],
                                                 // right_window_owner[75:74], zero pad
  input  wire logic              cfg_wr_en,
  input  wire logic [DutyW-1:0]  cfg_wr_data
);

  logic              s1_valid;
  logic [ZoneW-1:0]  s1_zone;
  logic [PidW-1:0]   s1_pid;
  logic              out_valid;
  result_t           res;
  logic [DutyW-1:0]  vent_threshold;
  logic [OwnW-1:0]   left_owner;
  logic [OwnW-1:0]   right_owner;

  logic              out_adv;
  logic              neg;
  logic [PidW-1:0]   mag_in;
  logic [ProdW-1:0]  prod;
  logic [DutyW-1:0]  q;
  logic [DriveW-1:0] drive;
  logic              vent;
  win_upd_t          lupd;
  win_upd_t          rupd;
  result_t           res_next;
  logic [OwnW-1:0]   left_owner_next;
  logic [OwnW-1:0]   right_owner_next;

  assign out_adv       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || out_adv;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutW - ResultW){1'b0}}, res};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      s1_zone <= s_axis_tdata[ZoneW-1:0];
      s1_pid  <= s_axis_tdata[ZoneW+PidW-1:ZoneW];
    end
  end

  // sign-magnitude divide: trunc toward zero
  always_comb begin
    neg    = s1_pid[PidW-1];
    mag_in = neg ? (~s1_pid + 1'b1) : s1_pid;
    prod   = ProdW'(mag_in) * ProdW'(RECIP_MULT);
    q      = prod[RECIP_SHIFT+DutyW-1:RECIP_SHIFT];
    drive  = neg ? (~{1'b0, q} + 1'b1) : {1'b0, q};
    vent   = neg && (q > vent_threshold);
  end

  always_comb begin
    lupd             = window_update(left_owner, LEFT_WIN_LEFT, vent);
    rupd             = window_update(right_owner, RIGHT_WIN_RIGHT, vent);
    left_owner_next  = left_owner;
    right_owner_next = right_owner;

    res_next.zone_echo          = s1_zone;
    res_next.drive              = drive;
    res_next.fan_duty           = q;
    res_next.heater_duty        = neg ? '0 : q;
    res_next.exhaust_duty       = vent ? q : '0;
    res_next.exhaust_side       = SIDE_LEFT;
    res_next.left_window_cmd    = CMD_NONE;
    res_next.right_window_cmd   = CMD_NONE;

    case (s1_zone)
      ZONE_LEFT: begin
        lupd                      = window_update(left_owner, LEFT_WIN_LEFT, vent);
        left_owner_next           = lupd.owner;
        res_next.left_window_cmd  = lupd.cmd;
      end
      ZONE_MID: begin
        lupd                      = window_update(left_owner, LEFT_WIN_MID, vent);
        rupd                      = window_update(right_owner, RIGHT_WIN_MID, vent);
        left_owner_next           = lupd.owner;
        right_owner_next          = rupd.owner;
        res_next.left_window_cmd  = lupd.cmd;
        res_next.right_window_cmd = rupd.cmd;
      end
      ZONE_RIGHT: begin
        rupd                      = window_update(right_owner, RIGHT_WIN_RIGHT, vent);
        right_owner_next          = rupd.owner;
        res_next.right_window_cmd = rupd.cmd;
        res_next.exhaust_side     = SIDE_RIGHT;
      end
      default: begin
        res_next.exhaust_duty = '0;
      end
    endcase

    res_next.left_window_owner  = left_owner_next;
    res_next.right_window_owner = right_owner_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      left_owner     <= OWN_FREE;
      right_owner    <= OWN_FREE;
      vent_threshold <= VENT_THRESHOLD_RESET;
    end else begin
      if (!out_valid || m_axis_tready) begin
        out_valid <= s1_valid;
      end
      if (out_adv) begin
        left_owner  <= left_owner_next;
        right_owner <= right_owner_next;
      end
      if (cfg_wr_en) begin
        vent_threshold <= cfg_wr_data;
      end
    end
    if (out_adv) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_owner_hold: assert property (@(posedge clk) disable iff (rst)
    !out_adv |=> ($stable(left_owner) && $stable(right_owner)))
    else $error("window owner changed without an item");

  a_exhaust_mag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.exhaust_duty != '0) |->
      (res.exhaust_duty == res.fan_duty && res.drive[DriveW-1] && res.heater_duty == '0))
    else $error("exhaust duty without negative drive");

  a_open_owned: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (res.left_window_cmd == CMD_OPEN || res.right_window_cmd == CMD_OPEN)) |->
      ((res.left_window_cmd != CMD_OPEN || res.left_window_owner != OWN_FREE) &&
       (res.right_window_cmd != CMD_OPEN || res.right_window_owner != OWN_FREE)))
    else $error("window opened but left free");

  a_close_frees: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.left_window_cmd == CMD_CLOSE) |-> (res.left_window_owner == OWN_FREE))
    else $error("left window closed but still owned");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_zone_actuator_window_ownership.sv -----
`timescale 1ns / 100ps

module tb_zone_actuator_window_ownership;
  import zawo_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [InW-1:0]     s_axis_tdata = '0;    // zone[1:0], pid_out[17:2], zero pad
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OutW-1:0]    m_axis_tdata;         // zone_echo, drive, fan_duty, heater_duty,
                                            // exhaust_duty, exhaust_side, left/right cmd,
                                            // left/right owner, zero pad
  logic               cfg_wr_en = 1'b0;
  logic [DutyW-1:0]   cfg_wr_data = '0;

  logic [InW-1:0]     pending_items[$];
  result_t            expected_duties[$];
  logic [DutyW-1:0]   vent_thr = VENT_THRESHOLD_RESET;
  logic [OwnW-1:0]    left_owner = OWN_FREE;
  logic [OwnW-1:0]    right_owner = OWN_FREE;
  int                 mismatches = 0;
  int                 hold_ask = 0;
  int                 hold_done = 0;

  zone_actuator_window_ownership dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("** zone_actuator_window_ownership: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  function automatic win_upd_t arbitrate_window(input logic [OwnW-1:0] owner,
                                                input logic [OwnW-1:0] me,
                                                input logic venting);
    win_upd_t u;
    u.cmd   = CMD_NONE;
    u.owner = owner;
    if (venting && owner == OWN_FREE) begin
      u.cmd   = CMD_OPEN;
      u.owner = me;
    end else if (!venting && owner == me) begin
      u.cmd   = CMD_CLOSE;
      u.owner = OWN_FREE;
    end
    return u;
  endfunction

  task automatic predict_duties(input logic [ZoneW-1:0] zone, input logic signed [PidW-1:0] pid);
    result_t  r;
    int       drv;
    int       mag;
    logic     venting;
    win_upd_t u;
    drv     = (int'(pid) * 32) / 25;
    mag     = (drv < 0) ? -drv : drv;
    venting = drv < -int'(vent_thr);
    r = '0;
    r.zone_echo   = zone;
    r.drive       = drv[DriveW-1:0];
    r.fan_duty    = mag[DutyW-1:0];
    r.heater_duty = (drv > 0) ? drv[DutyW-1:0] : '0;
    r.exhaust_side = SIDE_LEFT;
    case (zone)
      ZONE_LEFT: begin
        u = arbitrate_window(left_owner, LEFT_WIN_LEFT, venting);
        left_owner = u.owner;
        r.left_window_cmd = u.cmd;
      end
      ZONE_MID: begin
        u = arbitrate_window(left_owner, LEFT_WIN_MID, venting);
        left_owner = u.owner;
        r.left_window_cmd = u.cmd;
        u = arbitrate_window(right_owner, RIGHT_WIN_MID, venting);
        right_owner = u.owner;
        r.right_window_cmd = u.cmd;
      end
      ZONE_RIGHT: begin
        u = arbitrate_window(right_owner, RIGHT_WIN_RIGHT, venting);
        right_owner = u.owner;
        r.right_window_cmd = u.cmd;
        r.exhaust_side = SIDE_RIGHT;
      end
      default: ;
    endcase
    if (zone != 2'd3 && venting)
      r.exhaust_duty = mag[DutyW-1:0];
    r.left_window_owner  = left_owner;
    r.right_window_owner = right_owner;
    expected_duties.push_back(r);
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_duties(s_axis_tdata[1:0], s_axis_tdata[17:2]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          s_axis_tdata  <= pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern changes mode now and then; long hold on request
  int hold_left = 0;
  int mode_left = 0;
  int rx_mode = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
      mode_left = 0;
    end else begin
      if (hold_left == 0 && hold_done != hold_ask) begin
        hold_done++;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 120);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got = m_axis_tdata[ResultW-1:0];
      if (expected_duties.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_duties.pop_front();
        check_field("zone_echo", got.zone_echo, want.zone_echo);
        check_field("drive", got.drive, want.drive);
        check_field("fan_duty", got.fan_duty, want.fan_duty);
        check_field("heater_duty", got.heater_duty, want.heater_duty);
        check_field("exhaust_duty", got.exhaust_duty, want.exhaust_duty);
        check_field("exhaust_side", got.exhaust_side, want.exhaust_side);
        check_field("left_window_cmd", got.left_window_cmd, want.left_window_cmd);
        check_field("right_window_cmd", got.right_window_cmd, want.right_window_cmd);
        check_field("left_window_owner", got.left_window_owner, want.left_window_owner);
        check_field("right_window_owner", got.right_window_owner, want.right_window_owner);
      end
    end
  end

  task automatic queue_item(input logic [ZoneW-1:0] zone, input int pid);
    logic [InW-1:0] w;
    w = '0;
    w[1:0]  = zone;
    w[17:2] = pid[PidW-1:0];
    pending_items.push_back(w);
  endtask

  task automatic queue_random(input int n);
    int   pid;
    int   sel;
    logic [ZoneW-1:0] zone;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 15);
      zone = (sel == 0) ? 2'd3 : ZoneW'(sel % 3);
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        pid = -int'($urandom_range(0, 32768));
      end else if (sel < 7) begin
        // around the vent edge
        pid = -((int'(vent_thr) * 25) / 32) + int'($urandom_range(0, 8)) - 4;
        if (pid < -32768) pid = -32768;
        if (pid > 32767) pid = 32767;
      end else begin
        pid = int'($urandom_range(0, 65535));
      end
      queue_item(zone, pid);
    end
  endtask

  task automatic wait_drained;
    while (pending_items.size() != 0 || s_axis_tvalid || expected_duties.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [DutyW-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    vent_thr = v;
  endtask

  initial begin : stimulus
    int unsigned thr_list[6];
    thr_list = '{0, 65535, 41942, 0, 2560, 41943};
    thr_list[3] = $urandom_range(1, 41943);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ownership walk at the reset threshold
    queue_item(ZONE_LEFT, -32768);   // opens left window
    queue_item(ZONE_MID, -32768);    // left refused, right opened
    queue_item(ZONE_RIGHT, -32768);  // right held by middle
    queue_item(ZONE_RIGHT, 32767);   // not owner, no close
    queue_item(ZONE_MID, 0);         // closes right only
    queue_item(ZONE_RIGHT, -5000);   // opens right
    queue_item(ZONE_LEFT, 100);      // closes left
    queue_item(ZONE_MID, -2000);     // drive exactly at -threshold, no vent
    queue_item(ZONE_MID, -2001);     // just past it, opens left
    queue_item(ZONE_LEFT, -32768);   // left held by middle
    queue_item(ZONE_LEFT, 0);        // not owner
    queue_item(2'd3, -32768);
    queue_item(2'd3, 32767);
    queue_item(ZONE_MID, 32767);     // closes left
    queue_item(ZONE_RIGHT, 1);       // closes right
    queue_item(ZONE_LEFT, -1);
    queue_item(ZONE_LEFT, 'h5555);
    queue_item(ZONE_MID, -'h5556);
    queue_item(ZONE_RIGHT, -32767);
    queue_item(2'd3, 0);
    wait_drained();

    foreach (thr_list[i]) begin
      write_threshold(thr_list[i][DutyW-1:0]);
      @(negedge clk);
      queue_random(240);
      if (thr_list[i] == 2560)
        hold_ask++;
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("** zone_actuator_window_ownership: PASSED **");
    else
      $display("** zone_actuator_window_ownership: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/zawo_pkg.sv
rtl/core/zone_actuator_window_ownership.sv
tb/sv/tb_zone_actuator_window_ownership.sv
